@@ design/windowed_average_min_max_macros.svh @@
// Assertion helpers used by the windowed_average_min_max design file
`ifndef WINDOWED_AVERAGE_MIN_MAX_MACROS_SVH
`define WINDOWED_AVERAGE_MIN_MAX_MACROS_SVH

// same-cycle implication
`define WAMA_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WAMA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/wama_pkg.sv @@
package wama_pkg;

	localparam int SAMPLE_W = 16;
	localparam int CFG_W = 7;
	localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd60;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [CFG_W-1:0] cfg_t;

endpackage

@@ design/wama_sample_if.sv @@
interface wama_sample_if;
	logic valid;
	logic ready;
	wama_pkg::sample_t speed_sample;

	modport source (output valid, output speed_sample, input ready);
	modport sink (input valid, input speed_sample, output ready);
endinterface

@@ design/wama_result_if.sv @@
interface wama_result_if;
	logic valid;
	logic ready;
	wama_pkg::sample_t current_speed;
	wama_pkg::sample_t average_speed;
	wama_pkg::sample_t minimum_speed;
	wama_pkg::sample_t maximum_speed;

	modport source (output valid, output current_speed, output average_speed,
		output minimum_speed, output maximum_speed, input ready);
	modport sink (input valid, input current_speed, input average_speed,
		input minimum_speed, input maximum_speed, output ready);
endinterface

@@ design/wama_div.sv @@
// Restoring divider, one quotient bit per cycle
module wama_div #(
	parameter int DW = 22,
	parameter int VW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);

	localparam int CNTW = $clog2(DW + 1);

	logic [DW-1:0]   quo_q;
	logic [VW-1:0]   rem_q;
	logic [VW-1:0]   dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [VW:0] rem_sh;
	logic [VW:0] diff;
	logic        qbit;

	always_comb begin
		rem_sh = {rem_q, quo_q[DW-1]};
		diff   = rem_sh - {1'b0, dvs_q};
		qbit   = (rem_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], qbit};
			rem_q <= qbit ? diff[VW-1:0] : rem_sh[VW-1:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

@@ design/windowed_average_min_max.sv @@
// Channel    Dir  Word
// sample_ch  in   speed_sample
// result_ch  out  current_speed, average_speed, minimum_speed, maximum_speed
// cfg        in   cfg_we / cfg_wdata (window size; user writes it only when idle, unchecked)
//
// The average is computed by the bit-serial divider.
// sample_ch.ready is high only while the sequencer is idle.
// A result waits in the output register; a stalled result holds the sequencer
// in its last step but the next word can be taken once the result is loaded.
// Reset clears control state and the window; the ring needs no clearing.
module windowed_average_min_max #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  wama_pkg::cfg_t      cfg_wdata,
	wama_sample_if.sink         sample_ch,
	wama_result_if.source       result_ch
);

`include "windowed_average_min_max_macros.svh"

	localparam int SLW = $clog2(WINDOW_MAX);
	localparam int HW  = $clog2(WINDOW_MAX + 1);
	localparam int SW  = wama_pkg::SAMPLE_W + SLW;
	localparam int CW  = (HW > wama_pkg::CFG_W) ? HW : wama_pkg::CFG_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_GO   = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]          state_q;
	wama_pkg::cfg_t      size_q;
	logic [SW-1:0]       sum_q;
	logic [HW-1:0]       held_q;
	logic [SLW-1:0]      wslot_q;
	logic [SLW-1:0]      slot_q;
	wama_pkg::sample_t   smp_q;
	wama_pkg::sample_t   old_q;
	wama_pkg::sample_t   low_q;
	wama_pkg::sample_t   high_q;
	logic                ext_valid_q;
	wama_pkg::sample_t   ring_q [WINDOW_MAX];

	logic                out_valid_q;
	wama_pkg::sample_t   cur_q;
	wama_pkg::sample_t   avg_q;
	wama_pkg::sample_t   min_q;
	wama_pkg::sample_t   max_q;

	logic [CW-1:0]       size_x;
	logic [HW-1:0]       w_eff;
	logic [SLW-1:0]      slot_eff;
	logic [HW-1:0]       slot_inc;
	logic                accept;
	logic                full;
	logic                load_out;
	logic                div_start;
	logic                div_done;
	logic [SW-1:0]       div_quo;

	always_comb begin
		size_x = CW'(size_q);
		if (size_q == '0)
			w_eff = HW'(1);
		else if (size_x > CW'(WINDOW_MAX))
			w_eff = HW'(WINDOW_MAX);
		else
			w_eff = HW'(size_x);
		slot_eff  = (HW'(wslot_q) >= w_eff) ? '0 : wslot_q;
		slot_inc  = HW'(slot_q) + HW'(1);
		full      = (held_q >= w_eff);
		accept    = sample_ch.valid && sample_ch.ready;
		load_out  = (state_q == ST_DONE) && (!out_valid_q || result_ch.ready);
		div_start = (state_q == ST_GO);
	end

	assign sample_ch.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= wama_pkg::WINDOW_RESET;
			sum_q       <= '0;
			held_q      <= '0;
			wslot_q     <= '0;
			low_q       <= '0;
			high_q      <= '0;
			ext_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (result_ch.valid && result_ch.ready)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				size_q  <= cfg_wdata;
				sum_q   <= '0;
				held_q  <= '0;
				wslot_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_UPD;
				ST_UPD: begin
					if (full) begin
						sum_q  <= sum_q - SW'(old_q) + SW'(smp_q);
						held_q <= w_eff;
					end else begin
						sum_q  <= sum_q + SW'(smp_q);
						held_q <= held_q + HW'(1);
					end
					wslot_q <= (slot_inc >= w_eff) ? '0 : slot_inc[SLW-1:0];
					if (!ext_valid_q || smp_q < low_q)
						low_q <= smp_q;
					if (!ext_valid_q || smp_q > high_q)
						high_q <= smp_q;
					ext_valid_q <= 1'b1;
					state_q <= ST_GO;
				end
				ST_GO: state_q <= ST_DIV;
				ST_DIV: begin
					if (div_done)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q  <= sample_ch.speed_sample;
			slot_q <= slot_eff;
		end
		if (load_out) begin
			cur_q <= smp_q;
			avg_q <= div_quo[wama_pkg::SAMPLE_W-1:0];
			min_q <= low_q;
			max_q <= high_q;
		end
	end

	// ring: read in ST_RD, written in ST_UPD
	always_ff @(posedge clk) begin
		if (state_q == ST_RD)
			old_q <= ring_q[slot_q];
		if (state_q == ST_UPD)
			ring_q[slot_q] <= smp_q;
	end

	wama_div #(
		.DW (SW),
		.VW (HW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (held_q),
		.quotient (div_quo),
		.done     (div_done)
	);

	assign result_ch.valid         = out_valid_q;
	assign result_ch.current_speed = cur_q;
	assign result_ch.average_speed = avg_q;
	assign result_ch.minimum_speed = min_q;
	assign result_ch.maximum_speed = max_q;

	`WAMA_ASSERT_NOW(a_held_le_max, clk, arst_n, 1'b1, held_q <= HW'(WINDOW_MAX), "held overflow")
	`WAMA_ASSERT_NOW(a_busy_not_ready, clk, arst_n, state_q != ST_IDLE, !sample_ch.ready, "ready busy")
	`WAMA_ASSERT_NEXT(a_div_to_done, clk, arst_n, state_q == ST_DIV && div_done, state_q == ST_DONE, "div")
	`WAMA_ASSERT_NEXT(a_upd_extremes, clk, arst_n, state_q == ST_UPD, ext_valid_q && low_q <= high_q, "ext")

endmodule

@@ verif/wama_checker.sv @@
`timescale 1ns / 1ps

module wama_checker import wama_pkg::*; #(
	parameter int WINDOW_MAX = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  cfg_t   cfg_wdata,
	wama_sample_if sample_mon,
	wama_result_if result_mon,
	output int     mismatches,
	output int     words_seen,
	output int     pending
);

	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_MAX);
	localparam int HELD_W = $clog2(WINDOW_MAX + 1);
	localparam int SLOT_W = $clog2(WINDOW_MAX);

	typedef logic [HELD_W-1:0] held_t;

	typedef struct packed {
		sample_t cur;
		sample_t avg;
		sample_t low;
		sample_t high;
	} speed_report_t;

	speed_report_t expected_reports[$];

	sample_t           speed_ring [WINDOW_MAX];
	logic [SUM_W-1:0]  ring_total;
	held_t             held_count;
	held_t             next_slot;
	sample_t           lowest_speed;
	sample_t           highest_speed;
	logic              extremes_seen;
	cfg_t              window_reg;
	int                bad_count;
	int                taken_count;

	function automatic held_t window_span(cfg_t setting);
		if (setting == '0)
			return held_t'(1);
		if (setting > WINDOW_MAX)
			return held_t'(WINDOW_MAX);
		return held_t'(setting);
	endfunction

	task automatic note_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		bad_count++;
	endtask

	task automatic check_field(input string name, input sample_t got, input sample_t want);
		if (got !== want)
			note_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	task automatic take_speed(input sample_t s, output speed_report_t r);
		held_t w;
		held_t nxt;
		w = window_span(window_reg);
		if (next_slot >= w)
			next_slot = '0;
		if (held_count >= w) begin
			ring_total = ring_total - speed_ring[next_slot[SLOT_W-1:0]];
			held_count = w;
		end else begin
			held_count = held_count + 1'b1;
		end
		speed_ring[next_slot[SLOT_W-1:0]] = s;
		ring_total = ring_total + s;
		nxt = next_slot + 1'b1;
		next_slot = (nxt >= w) ? '0 : nxt;
		if (!extremes_seen || s < lowest_speed)
			lowest_speed = s;
		if (!extremes_seen || s > highest_speed)
			highest_speed = s;
		extremes_seen = 1'b1;
		r.cur = s;
		r.avg = sample_t'(ring_total / held_count);
		r.low = lowest_speed;
		r.high = highest_speed;
	endtask

	always @(posedge clk or negedge arst_n) begin
		speed_report_t rep;
		if (!arst_n) begin
			expected_reports.delete();
			ring_total = '0;
			held_count = '0;
			next_slot = '0;
			lowest_speed = '0;
			highest_speed = '0;
			extremes_seen = 1'b0;
			window_reg = WINDOW_RESET;
			bad_count = 0;
			taken_count = 0;
		end else begin
			if (cfg_we) begin
				window_reg = cfg_wdata;
				ring_total = '0;
				held_count = '0;
				next_slot = '0;
			end
			if (sample_mon.valid && sample_mon.ready) begin
				take_speed(sample_mon.speed_sample, rep);
				expected_reports.push_back(rep);
				taken_count++;
			end
			if (result_mon.valid && result_mon.ready) begin
				if (expected_reports.size() == 0) begin
					note_mismatch("result word with nothing expected");
				end else begin
					rep = expected_reports.pop_front();
					check_field("current_speed", result_mon.current_speed, rep.cur);
					check_field("average_speed", result_mon.average_speed, rep.avg);
					check_field("minimum_speed", result_mon.minimum_speed, rep.low);
					check_field("maximum_speed", result_mon.maximum_speed, rep.high);
				end
			end
		end
		mismatches <= bad_count;
		words_seen <= taken_count;
		pending <= expected_reports.size();
	end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
	import wama_pkg::*;

	localparam int WINDOW_MAX = 64;
	localparam int WORD_TARGET = 950;
	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE = 40;

	typedef enum int {STYLE_ANY, STYLE_EDGE, STYLE_NEAR, STYLE_TOP, STYLE_BIT} speed_style_e;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_t cfg_wdata;
	logic calm;
	int   cycles;
	int   mismatches;
	int   words_seen;
	int   pending;
	int   settings_used;

	wama_sample_if sample_ch ();
	wama_result_if result_ch ();

	windowed_average_min_max #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_ch),
		.result_ch (result_ch)
	);

	wama_checker #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.sample_mon (sample_ch),
		.result_mon (result_ch),
		.mismatches (mismatches),
		.words_seen (words_seen),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		calm = 1'b0;
		cycles = 0;
		sample_ch.valid = 1'b0;
		sample_ch.speed_sample = '0;
		result_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		result_ch.ready <= calm || ($urandom_range(99) >= 14);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped at cycle %0d with %0d words outstanding", cycles, pending);
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_word(input sample_t v);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(99) < 14)
			gap = $urandom_range(1, 30);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.speed_sample <= v;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_window(input cfg_t setting);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= setting;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic sample_t next_speed(speed_style_e style, sample_t base);
		if (style != STYLE_TOP && $urandom_range(9) < 3)
			return sample_t'($urandom);
		case (style)
			STYLE_EDGE: begin
				case ($urandom_range(3))
					0: return '0;
					1: return '1;
					2: return sample_t'(1);
					default: return sample_t'(16'hFFFE);
				endcase
			end
			STYLE_NEAR: return base + sample_t'($urandom_range(0, 15)) - sample_t'(8);
			STYLE_TOP: return '1;
			STYLE_BIT: begin
				if ($urandom_range(1))
					return sample_t'(1) << $urandom_range(15);
				return ~(sample_t'(1) << $urandom_range(15));
			end
			default: return sample_t'($urandom);
		endcase
	endfunction

	initial begin
		int phase;
		int len;
		int random_words;
		cfg_t setting;
		speed_style_e style;
		sample_t base;

		settings_used = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window; first word sets both extremes
		send_word(16'd1000);
		send_word(16'd1200);
		send_word(16'd900);
		send_word(16'hFFFF);
		send_word(16'h0000);
		send_word(16'h5555);
		send_word(16'hAAAA);
		send_word(16'h0001);
		send_word(16'h8000);
		send_word(16'h7FFF);
		// zero means a window of one
		write_window(cfg_t'(0));
		send_word(16'hFFFF);
		send_word(16'd3);
		write_window(cfg_t'(2));
		send_word(16'd10);
		send_word(16'd20);
		send_word(16'd30);
		send_word(16'hFFFF);
		// oversize window saturates
		write_window('1);
		send_word(16'hFFFF);
		send_word(16'h0000);
		write_window(cfg_t'(1));
		send_word(16'd7);
		send_word(16'hFFFE);
		write_window(cfg_t'(WINDOW_MAX + 1));
		send_word(16'd100);
		send_word(16'd200);

		phase = 0;
		random_words = 0;
		while (random_words < WORD_TARGET) begin
			base = sample_t'($urandom);
			case (phase)
				0: begin
					setting = cfg_t'(WINDOW_MAX);
					style = STYLE_TOP;
					len = 80;
				end
				1: begin
					setting = '1;
					style = STYLE_EDGE;
					len = 90;
				end
				default: begin
					case ($urandom_range(9))
						0: setting = cfg_t'(0);
						1: setting = cfg_t'(1);
						2: setting = cfg_t'(2);
						3: setting = cfg_t'(3);
						4: setting = cfg_t'(WINDOW_MAX - 1);
						5: setting = cfg_t'(WINDOW_MAX + 1);
						6: setting = WINDOW_RESET;
						default: setting = cfg_t'($urandom_range(0, 127));
					endcase
					style = speed_style_e'($urandom_range(STYLE_BIT));
					len = $urandom_range(20, 130);
				end
			endcase
			calm = (phase == 2);
			if (phase < 3 || $urandom_range(4) != 0)
				write_window(setting);
			for (int i = 0; i < len && random_words < WORD_TARGET; i++) begin
				send_word(next_speed(style, base));
				random_words++;
				if (!calm && $urandom_range(99) < 3)
					drain();
			end
			phase++;
		end
		calm = 1'b0;

		drain();
		$display("%0d speed words checked over %0d window settings and %0d random phases",
			words_seen, settings_used, phase);
		$display("%0d mismatching fields", mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
